@@ hdl/modmul_pkg.sv @@
// Shared types for the interleaved modular multiplier.
// Holds the command bundle from the controller to the datapath.
// No dependencies.
package modmul_pkg;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture operands, clear remainder and accumulator
		logic reduce;  // one restoring-remainder step on the multiplicand
		logic mult;    // one interleaved add/double step on the multiplier
		logic store;   // move the result into the output register
	} modmul_cmd_t;

endpackage

@@ hdl/modmul_dp.sv @@
// Datapath of the interleaved modular multiplier: operand registers,
// remainder unit, add/double unit and the output register.
// Depends on modmul_pkg.
module modmul_dp
	import modmul_pkg::*;
#(
	parameter int W = 31
) (
	input  logic        clk,
	input  modmul_cmd_t cmd,
	input  logic [W-1:0] multiplicand,
	input  logic [W-1:0] multiplier,
	input  logic [W-1:0] modulus,
	output logic [W-1:0] product_mod,
	output logic         status
);

	logic [W-1:0] a_q;    // multiplicand, shifted out MSB first
	logic [W-1:0] b_q;    // multiplier, shifted out LSB first
	logic [W-1:0] m_q;
	logic [W-1:0] r_q;    // reduced multiplicand, doubled each step
	logic [W-1:0] acc_q;
	logic [W-1:0] res_q;
	logic         err_q;

	logic [W:0]   rem_sh;
	logic [W-1:0] rem_nxt;
	logic [W:0]   acc_sum;
	logic [W-1:0] acc_nxt;
	logic [W:0]   dbl_sum;
	logic [W-1:0] dbl_nxt;

	// Remainder step: shift in next multiplicand bit, subtract if not below m
	always_comb begin
		rem_sh = {r_q, a_q[W-1]};
		if (rem_sh >= {1'b0, m_q}) begin
			rem_sh = rem_sh - {1'b0, m_q};
		end
		rem_nxt = rem_sh[W-1:0];
	end

	// Add/double step: both sums stay below 2m, one conditional subtract each
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, r_q};
		if (acc_sum >= {1'b0, m_q}) begin
			acc_sum = acc_sum - {1'b0, m_q};
		end
		acc_nxt = acc_q;
		if (b_q[0]) begin
			acc_nxt = acc_sum[W-1:0];
		end
		dbl_sum = {r_q, 1'b0};
		if (dbl_sum >= {1'b0, m_q}) begin
			dbl_sum = dbl_sum - {1'b0, m_q};
		end
		dbl_nxt = dbl_sum[W-1:0];
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= multiplicand;
			b_q   <= multiplier;
			m_q   <= modulus;
			r_q   <= '0;
			acc_q <= '0;
		end else if (cmd.reduce) begin
			a_q <= {a_q[W-2:0], 1'b0};
			r_q <= rem_nxt;
		end else if (cmd.mult) begin
			acc_q <= acc_nxt;
			r_q   <= dbl_nxt;
			b_q   <= {1'b0, b_q[W-1:1]};
		end
	end

	// Output register; a zero modulus forces a zero result with error status
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			err_q <= (m_q == '0);
			res_q <= (m_q == '0) ? '0 : acc_q;
		end
	end

	assign product_mod = res_q;
	assign status      = err_q;

endmodule

@@ hdl/modmul_ctrl.sv @@
// Controller of the interleaved modular multiplier: sequences the
// remainder and add/double phases and owns both handshakes.
// Depends on modmul_pkg.
module modmul_ctrl
	import modmul_pkg::*;
#(
	parameter int W = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output modmul_cmd_t cmd
);

	localparam int CW = $clog2(W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MULT,
		ST_STORE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          m_tvalid_q;
	logic          last_step;
	logic          out_free;

	assign last_step = (cnt_q == CW'(W - 1));
	assign out_free  = !m_tvalid_q || m_tready;

	// Commands decoded from state
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && s_tvalid;
		cmd.reduce = (state_q == ST_REDUCE);
		cmd.mult   = (state_q == ST_MULT);
		cmd.store  = (state_q == ST_STORE) && out_free;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// State, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a store in the same cycle keeps valid high for the new result
			if (m_tvalid_q && m_tready && !cmd.store) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (last_step) begin
						cnt_q   <= '0;
						state_q <= ST_MULT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MULT: begin
					if (last_step) begin
						cnt_q   <= '0;
						state_q <= ST_STORE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_STORE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (!m_tvalid_q || m_tready))
		else $error("result stored over an untaken transaction");
	a_store_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> m_tvalid)
		else $error("stored result not presented");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_REDUCE) && (cnt_q == '0))
		else $error("accepted transaction did not start reduction");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(W - 1))
		else $error("step counter out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) |-> !s_tready)
		else $error("input ready while multiplying");
`endif

endmodule

@@ hdl/modular_multiply.sv @@
// Interleaved modular multiplier: product_mod = (multiplicand * multiplier) mod modulus.
// Each transaction runs one remainder step per multiplicand bit, then one add/double step
// per multiplier bit, then a store into the output register that raises m_tvalid; no new
// input transaction is accepted until that store has happened.
// A result waiting on m_tready stalls the next store, which holds off the next input.
// Reset (arst_n, asynchronous, active low) clears the controller; no stored data.
module modular_multiply
	import modmul_pkg::*;
#(
	parameter int OPERAND_WIDTH = 31
) (
	input  logic clk,
	input  logic arst_n,
	// [W-1:0] multiplicand, [2W-1:W] multiplier, [3W-1:2W] modulus, zero pad
	input  logic [((3*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// [W-1:0] product_mod, zero pad
	output logic [((OPERAND_WIDTH+7)/8)*8-1:0] m_tdata,
	// [0] status (1 = zero modulus)
	output logic m_tuser,
	output logic m_tvalid,
	input  logic m_tready
);

	localparam int W      = OPERAND_WIDTH;
	localparam int OUT_TW = ((OPERAND_WIDTH + 7) / 8) * 8;

	modmul_cmd_t  cmd;
	logic [W-1:0] product_mod;
	logic         status;

	// Sequencer
	modmul_ctrl #(.W(W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Arithmetic
	modmul_dp #(.W(W)) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.multiplicand (s_tdata[W-1:0]),
		.multiplier   (s_tdata[2*W-1:W]),
		.modulus      (s_tdata[3*W-1:2*W]),
		.product_mod  (product_mod),
		.status       (status)
	);

	assign m_tdata = OUT_TW'(product_mod);
	assign m_tuser = status;

endmodule
